// File: hdl/box_overlap_against_map_top_macros.svh
`ifndef BOX_OVERLAP_AGAINST_MAP_TOP_MACROS_SVH
`define BOX_OVERLAP_AGAINST_MAP_TOP_MACROS_SVH

// plain property checked every cycle out of reset
`define BOM_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked every cycle out of reset
`define BOM_CHECK_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/bom_pkg.sv
package bom_pkg;

	typedef logic signed [15:0] coord_t;

	// input word kind codes
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_QUERY = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// result word kind codes
	localparam logic [1:0] PIECE_MORE = 2'd0;
	localparam logic [1:0] PIECE_LAST = 2'd1;
	localparam logic [1:0] PIECE_NONE = 2'd2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam int NUM_AXES = 3;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_QUERY,
		OP_CLEAR
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		op_t                 op;
		coord_t [2:0]        lo;
		coord_t [2:0]        hi;
		logic   [15:0]       owner;
		coord_t [2:0]        wrap;
		logic   [31:0]       tag;
	} cmd_t;

	typedef struct packed {
		coord_t [2:0]        lo;
		coord_t [2:0]        hi;
		logic   [15:0]       owner;
		coord_t [2:0]        wrap;
	} map_entry_t;

	typedef struct packed {
		coord_t [2:0]        lo;
		coord_t [2:0]        hi;
		logic   [15:0]       owner;
		coord_t [2:0]        wrap;
		logic   [31:0]       tag;
		logic   [1:0]        kind;
	} piece_t;

	// front to queue
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} push_t;

	// queue to back
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

endpackage

// File: hdl/bom_if.sv
interface bom_item_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  kind;
	logic signed [15:0] min_x;
	logic signed [15:0] min_y;
	logic signed [15:0] min_z;
	logic signed [15:0] max_x;
	logic signed [15:0] max_y;
	logic signed [15:0] max_z;
	logic        [15:0] owner;
	logic signed [15:0] wrap_x;
	logic signed [15:0] wrap_y;
	logic signed [15:0] wrap_z;
	logic        [31:0] tag;

	modport source (
		output valid, kind, min_x, min_y, min_z, max_x, max_y, max_z,
		output owner, wrap_x, wrap_y, wrap_z, tag,
		input  ready
	);
	modport sink (
		input  valid, kind, min_x, min_y, min_z, max_x, max_y, max_z,
		input  owner, wrap_x, wrap_y, wrap_z, tag,
		output ready
	);
endinterface

interface bom_piece_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] piece_min_x;
	logic signed [15:0] piece_min_y;
	logic signed [15:0] piece_min_z;
	logic signed [15:0] piece_max_x;
	logic signed [15:0] piece_max_y;
	logic signed [15:0] piece_max_z;
	logic        [15:0] piece_owner;
	logic signed [15:0] piece_wrap_x;
	logic signed [15:0] piece_wrap_y;
	logic signed [15:0] piece_wrap_z;
	logic        [31:0] piece_tag;
	logic        [1:0]  piece_kind;

	modport source (
		output valid, piece_min_x, piece_min_y, piece_min_z,
		output piece_max_x, piece_max_y, piece_max_z, piece_owner,
		output piece_wrap_x, piece_wrap_y, piece_wrap_z, piece_tag, piece_kind,
		input  ready
	);
	modport sink (
		input  valid, piece_min_x, piece_min_y, piece_min_z,
		input  piece_max_x, piece_max_y, piece_max_z, piece_owner,
		input  piece_wrap_x, piece_wrap_y, piece_wrap_z, piece_tag, piece_kind,
		output ready
	);
endinterface

// File: hdl/bom_ram.sv
module bom_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hdl/bom_front.sv
module bom_front
	import bom_pkg::*;
(
	bom_item_if.sink items,
	input  logic     q_full,
	output push_t    push
);

	logic accept;
	op_t  op;
	logic known;

	assign items.ready = !q_full;
	assign accept      = items.valid && items.ready;

	// decode the word kind, kind 3 is dropped here
	always_comb begin
		op    = OP_LOAD;
		known = 1'b1;
		case (items.kind)
			KIND_LOAD:  op = OP_LOAD;
			KIND_QUERY: op = OP_QUERY;
			KIND_CLEAR: op = OP_CLEAR;
			default:    known = 1'b0;
		endcase
	end

	always_comb begin
		push.valid     = accept && known;
		push.cmd.op    = op;
		push.cmd.lo    = {items.min_z, items.min_y, items.min_x};
		push.cmd.hi    = {items.max_z, items.max_y, items.max_x};
		push.cmd.owner = items.owner;
		push.cmd.wrap  = {items.wrap_z, items.wrap_y, items.wrap_x};
		push.cmd.tag   = items.tag;
	end

endmodule

// File: hdl/bom_queue.sv
module bom_queue
	import bom_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  full,
	input  logic  pop,
	output head_t head
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = slot_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/bom_back.sv
`include "box_overlap_against_map_top_macros.svh"

module bom_back
	import bom_pkg::*;
#(
	parameter int MAP_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [2:0] active_axes,
	input  head_t      head,
	output logic       pop,
	bom_piece_if.source pieces
);

	localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int CW = $clog2(MAP_DEPTH + 1);

	state_t        state_q, state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic          s1_valid_q;
	coord_t [2:0]  q_lo_q;
	coord_t [2:0]  q_hi_q;
	logic [31:0]   q_tag_q;
	logic          held_valid_q;
	piece_t        held_q;
	logic          out_valid_q;
	piece_t        out_q;

	logic          adv;
	logic          issue;
	logic          done;
	logic          load_ok;
	logic          out_load;
	piece_t        out_d;
	map_entry_t    wr_entry;
	map_entry_t    rd_entry;
	piece_t        cand;
	logic          hit;
	coord_t [2:0]  ilo;
	coord_t [2:0]  ihi;
	logic [2:0]    axis_ok;

	// output register can take a new word
	assign adv = !out_valid_q || pieces.ready;

	// fsm next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (head.valid && head.cmd.op == OP_QUERY) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (adv && done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		pop   = 1'b0;
		issue = 1'b0;
		done  = 1'b0;
		case (state_q)
			ST_IDLE: pop = head.valid;
			ST_SCAN: begin
				issue = adv && (idx_q < count_q);
				done  = (idx_q == count_q) && !s1_valid_q;
			end
			default: ;
		endcase
	end

	assign load_ok = pop && head.cmd.op == OP_LOAD && (count_q < CW'(MAP_DEPTH));

	always_comb begin
		wr_entry.lo    = head.cmd.lo;
		wr_entry.hi    = head.cmd.hi;
		wr_entry.owner = head.cmd.owner;
		wr_entry.wrap  = head.cmd.wrap;
	end

	bom_ram #(
		.WIDTH ($bits(map_entry_t)),
		.DEPTH (MAP_DEPTH)
	) u_map (
		.clk     (clk),
		.wr_en   (load_ok),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (wr_entry),
		.rd_en   (issue),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_entry)
	);

	// intersection of the stored box with the query, per axis
	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			ilo[a] = ($signed(rd_entry.lo[a]) > $signed(q_lo_q[a])) ? rd_entry.lo[a]
				: q_lo_q[a];
			ihi[a] = ($signed(rd_entry.hi[a]) < $signed(q_hi_q[a])) ? rd_entry.hi[a]
				: q_hi_q[a];
			axis_ok[a] = !active_axes[a] || !($signed(ihi[a]) < $signed(ilo[a]));
			cand.lo[a] = active_axes[a] ? ilo[a] : '0;
			cand.hi[a] = active_axes[a] ? ihi[a] : '0;
		end
		cand.owner = rd_entry.owner;
		cand.wrap  = rd_entry.wrap;
		cand.tag   = q_tag_q;
		cand.kind  = PIECE_MORE;
		hit        = s1_valid_q && (&axis_ok);
	end

	// one hit is held back so the last one can be marked
	always_comb begin
		out_load = 1'b0;
		out_d    = held_q;
		if (adv) begin
			if (hit && held_valid_q) begin
				out_load   = 1'b1;
				out_d.kind = PIECE_MORE;
			end else if (done) begin
				out_load = 1'b1;
				if (held_valid_q) begin
					out_d.kind = PIECE_LAST;
				end else begin
					out_d      = '0;
					out_d.tag  = q_tag_q;
					out_d.kind = PIECE_NONE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.cmd.op == OP_QUERY) begin
			q_lo_q  <= head.cmd.lo;
			q_hi_q  <= head.cmd.hi;
			q_tag_q <= head.cmd.tag;
		end
		if (adv && hit) begin
			held_q <= cand;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			s1_valid_q   <= 1'b0;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_ok) begin
				count_q <= count_q + 1'b1;
			end else if (pop && head.cmd.op == OP_CLEAR) begin
				count_q <= '0;
			end
			if (pop) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (adv) begin
				s1_valid_q <= issue;
			end
			if (adv && done) begin
				held_valid_q <= 1'b0;
			end else if (adv && hit) begin
				held_valid_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pieces.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign pieces.valid        = out_valid_q;
	assign pieces.piece_min_x  = out_q.lo[0];
	assign pieces.piece_min_y  = out_q.lo[1];
	assign pieces.piece_min_z  = out_q.lo[2];
	assign pieces.piece_max_x  = out_q.hi[0];
	assign pieces.piece_max_y  = out_q.hi[1];
	assign pieces.piece_max_z  = out_q.hi[2];
	assign pieces.piece_owner  = out_q.owner;
	assign pieces.piece_wrap_x = out_q.wrap[0];
	assign pieces.piece_wrap_y = out_q.wrap[1];
	assign pieces.piece_wrap_z = out_q.wrap[2];
	assign pieces.piece_tag    = out_q.tag;
	assign pieces.piece_kind   = out_q.kind;

	`BOM_CHECK(a_count_range, count_q <= CW'(MAP_DEPTH), "map count beyond depth")
	`BOM_CHECK_IMP(a_idle_clean, state_q == ST_IDLE, !s1_valid_q && !held_valid_q, "stale scan")
	`BOM_CHECK_IMP(a_idx_bound, state_q == ST_SCAN, idx_q <= count_q, "scan index past map count")
	`BOM_CHECK_IMP(a_no_pop_in_scan, state_q == ST_SCAN, !pop, "queue popped during a scan")

endmodule

// File: hdl/box_overlap_against_map_top.sv
// channel   | dir | handshake     | word
// ----------+-----+---------------+-------------------------------------------
// items     | in  | valid/ready   | kind, box corners, owner, wrap, tag
// pieces    | out | valid/ready   | intersection box, owner, wrap, tag, kind
// apb       | in  | psel/penable  | active_axes at byte address 0
//
// loads and clears are taken in the back end's idle state without a scan; a query
// scans the stored boxes, one stored box per cycle while pieces does not stall,
// through the single read port of the map ram
// a four word queue lets the front keep taking words while a query scans
// a stall on pieces freezes the scan; arst_n empties the map and queue
// the map ram needs no clearing pass, only the entry count is reset
module box_overlap_against_map_top
	import bom_pkg::*;
#(
	parameter int MAP_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	bom_item_if.sink    items,
	bom_piece_if.source pieces,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [2:0] active_axes_q;
	logic       reg_hit;
	push_t      push;
	head_t      head;
	logic       q_full;
	logic       pop;

	// register 0 only; low byte bits are ignored
	assign reg_hit = (paddr[2] == 1'b0);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? {29'd0, active_axes_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_axes_q <= 3'd7;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			active_axes_q <= pwdata[2:0];
		end
	end

	bom_front u_front (
		.items  (items),
		.q_full (q_full),
		.push   (push)
	);

	bom_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (pop),
		.head   (head)
	);

	bom_back #(
		.MAP_DEPTH (MAP_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.active_axes (active_axes_q),
		.head        (head),
		.pop         (pop),
		.pieces      (pieces)
	);

endmodule
